FILE: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked assertion that is checked during reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: rtl/dpea_pkg.sv
// shared widths, codes and control types of the dipolar pair energy accumulator
`default_nettype none
package dpea_pkg;

    localparam int DIST_W     = 24;
    localparam int STR_W      = 32;
    localparam int IMG_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int MAG_W      = 27;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int CUBE_W     = 3 * MAG_W;
    localparam int SUM_W      = 64;
    localparam int CNT_W      = 7;
    localparam int MAX_IMAGES = 4;

    localparam logic [IMG_W-1:0] MAX_IMG_CODE = IMG_W'(MAX_IMAGES);

    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    // term kinds
    localparam logic [1:0] KIND_BASE  = 2'd0;
    localparam logic [1:0] KIND_PLUS  = 2'd1;
    localparam logic [1:0] KIND_MINUS = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       sel;
        logic       sq;
        logic       cb_lo;
        logic       cb_hi;
        logic       div_step;
        logic       term;
        logic       acc;
        logic       adv;
        logic       emit;
        logic [1:0] kind;
    } dpea_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
        logic last_item;
    } dpea_stat_t;

endpackage
`default_nettype wire

FILE: rtl/dpea_ctrl.sv
// controller state machine: sequences terms, multiplier steps and the divider
`default_nettype none
module dpea_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dpea_pkg::IMG_W-1:0]    image_count,
    input  wire dpea_pkg::dpea_stat_t          stat,
    output dpea_pkg::dpea_cmd_t                cmd
);
    import dpea_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SEL   = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_CB_LO = 4'd3;
    localparam logic [3:0] ST_CB_HI = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_TERM  = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_ADV   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [IMG_W-1:0] k_reg, k_next;
    logic [IMG_W-1:0] n_reg, n_next;
    logic [1:0]       kind_reg, kind_next;
    logic [IMG_W-1:0] k_clamped;

    assign k_clamped = (image_count > MAX_IMG_CODE) ? MAX_IMG_CODE : image_count;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    k_next     = k_clamped;
                    n_next     = '0;
                    kind_next  = KIND_BASE;
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                cmd.sel    = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_CB_LO;
            end
            ST_CB_LO: begin
                cmd.cb_lo  = 1'b1;
                state_next = ST_CB_HI;
            end
            ST_CB_HI: begin
                cmd.cb_hi  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                cmd.term   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (kind_reg == KIND_PLUS) begin
                    kind_next  = KIND_MINUS;
                    state_next = ST_SEL;
                end else if (n_reg == k_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                cmd.adv    = 1'b1;
                n_next     = n_reg + 1'b1;
                kind_next  = KIND_PLUS;
                state_next = ST_SEL;
            end
            ST_FIN: begin
                if (!stat.last_item) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
            kind_reg  <= KIND_BASE;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            kind_reg  <= kind_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dpea_datapath.sv
// datapath: divisor select, shared multiplier, bit-serial divider, saturating sum
`default_nettype none
module dpea_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dpea_pkg::dpea_cmd_t           cmd,
    output dpea_pkg::dpea_stat_t               stat,
    input  wire logic [dpea_pkg::DIST_W-1:0]   s_distance,
    input  wire logic                          s_last,
    input  wire logic [dpea_pkg::STR_W-1:0]    strength,
    input  wire logic [dpea_pkg::DIST_W-1:0]   box_length,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [dpea_pkg::SUM_W-1:0]         m_energy,
    output logic                               m_saturated
);
    import dpea_pkg::*;

    logic [DIST_W-1:0] x_reg;
    logic              last_reg;
    logic [MAG_W-1:0]  nl_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              dneg_reg;
    logic [SQ_W-1:0]   m2_reg;
    logic [CUBE_W-1:0] cube_reg;
    logic [CUBE_W-1:0] rem_reg;
    logic [SUM_W-1:0]  q_reg;
    logic              qov_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  term_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              flag_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_energy_reg;
    logic              out_sat_reg;

    // divisor base
    logic [MAG_W-1:0] x_ext, mag_sel;
    logic             nl_lt_x;

    assign x_ext   = MAG_W'(x_reg);
    assign nl_lt_x = nl_reg < x_ext;

    always_comb begin
        case (cmd.kind)
            KIND_PLUS:  mag_sel = x_ext + nl_reg;
            KIND_MINUS: mag_sel = nl_lt_x ? (x_ext - nl_reg) : (nl_reg - x_ext);
            default:    mag_sel = x_ext;
        endcase
    end

    // shared 27x27 multiplier for square and the two cube partial products
    logic [MAG_W-1:0] mul_a;
    logic [SQ_W-1:0]  prod;

    always_comb begin
        if (cmd.sq) begin
            mul_a = mag_reg;
        end else if (cmd.cb_lo) begin
            mul_a = m2_reg[MAG_W-1:0];
        end else begin
            mul_a = m2_reg[SQ_W-1:MAG_W];
        end
    end

    assign prod = SQ_W'(mul_a) * SQ_W'(mag_reg);

    // restoring division of |D| * 2^64 by the cube, one quotient bit per cycle
    logic              s_neg;
    logic [STR_W-1:0]  a_mag;
    logic              div_bit;
    logic [CUBE_W:0]   r_sh;
    logic [CUBE_W+1:0] diff;
    logic              ge;

    assign s_neg   = strength[STR_W-1];
    assign a_mag   = s_neg ? (STR_W'(0) - strength) : strength;
    // numerator bits 95..64 carry |D|
    assign div_bit = (cnt_reg[CNT_W-1:CNT_W-2] == 2'b10) ? a_mag[cnt_reg[4:0]] : 1'b0;
    assign r_sh    = {rem_reg, div_bit};
    assign diff    = {1'b0, r_sh} - {2'b00, cube_reg};
    assign ge      = !diff[CUBE_W+1];

    // signed, saturated term
    logic             neg, mag_zero, a_zero, big;
    logic [SUM_W-1:0] lim, q_sat, term_val;
    logic             term_flag;

    assign neg      = s_neg ^ dneg_reg;
    assign mag_zero = (mag_reg == '0);
    assign a_zero   = (strength == '0);
    assign lim      = neg ? SUM_MIN : SUM_MAX;
    assign big      = qov_reg || (q_reg > lim);
    assign q_sat    = big ? lim : q_reg;

    always_comb begin
        if (mag_zero) begin
            term_flag = 1'b1;
            if (a_zero) begin
                term_val = '0;
            end else begin
                term_val = s_neg ? SUM_MIN : SUM_MAX;
            end
        end else if (a_zero) begin
            term_flag = 1'b0;
            term_val  = '0;
        end else begin
            term_flag = big;
            term_val  = neg ? (SUM_W'(0) - q_sat) : q_sat;
        end
    end

    // saturating accumulate
    logic [SUM_W-1:0] add_r;
    logic             add_ovf;

    assign add_r   = sum_reg + term_reg;
    assign add_ovf = (~(sum_reg[SUM_W-1] ^ term_reg[SUM_W-1])) &
                     (sum_reg[SUM_W-1] ^ add_r[SUM_W-1]);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= s_distance;
            last_reg <= s_last;
            nl_reg   <= '0;
        end
        if (cmd.adv) begin
            nl_reg <= nl_reg + MAG_W'(box_length);
        end
        if (cmd.sel) begin
            mag_reg  <= mag_sel;
            dneg_reg <= (cmd.kind == KIND_MINUS) && nl_lt_x;
        end
        if (cmd.sq) begin
            m2_reg <= prod;
        end
        if (cmd.cb_lo) begin
            cube_reg <= CUBE_W'(prod);
        end
        if (cmd.cb_hi) begin
            cube_reg <= cube_reg + {prod, {MAG_W{1'b0}}};
            rem_reg  <= '0;
            q_reg    <= '0;
            qov_reg  <= 1'b0;
            cnt_reg  <= '1;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? diff[CUBE_W-1:0] : r_sh[CUBE_W-1:0];
            q_reg   <= {q_reg[SUM_W-2:0], ge};
            qov_reg <= qov_reg | q_reg[SUM_W-1];
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.term) begin
            term_reg <= term_val;
        end
        if (cmd.emit) begin
            out_energy_reg <= sum_reg;
            out_sat_reg    <= flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.term && term_flag) begin
                flag_reg <= 1'b1;
            end
            if (cmd.acc) begin
                if (add_ovf) begin
                    sum_reg  <= sum_reg[SUM_W-1] ? SUM_MIN : SUM_MAX;
                    flag_reg <= 1'b1;
                end else begin
                    sum_reg <= add_r;
                end
            end
            if (cmd.emit) begin
                sum_reg       <= '0;
                flag_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.div_last  = (cnt_reg == '0);
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.last_item = last_reg;

    assign m_tvalid    = out_valid_reg;
    assign m_energy    = out_energy_reg;
    assign m_saturated = out_sat_reg;

endmodule
`default_nettype wire

FILE: rtl/dipolar_pair_energy_accumulator.sv
// Dipolar pair energy accumulator. Each accepted distance x adds D/x^3 and, for
// n = 1 to image_count (clamped to 4), D/(x+nL)^3 and D/(nL-x)^3 to a saturating
// Q32.32 running sum; a transaction with tlast set returns the total on m_tdata
// and the saturation flag on m_tuser, then clears both. Every term runs through
// one shared bit-serial divider that produces one of 128 quotient bits per cycle,
// so a term runs through select, three multiplier steps, 128 divide steps, term
// and accumulate. One item is in work at a time; the result register lets the
// next item be accepted while a total still waits on the output.
`default_nettype none
module dipolar_pair_energy_accumulator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,    // [23:0] distance
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // [63:0] energy
    output logic [0:0]       m_tuser,    // [0] saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import dpea_pkg::*;

    logic [STR_W-1:0]  strength_reg;
    logic [IMG_W-1:0]  image_count_reg;
    logic [DIST_W-1:0] box_length_reg;
    dpea_cmd_t         cmd;
    dpea_stat_t        stat;
    logic              saturated;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg    <= STR_W'(65536);
            image_count_reg <= '0;
            box_length_reg  <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STRENGTH:    strength_reg    <= cfg_data[STR_W-1:0];
                CFG_IMAGE_COUNT: image_count_reg <= cfg_data[IMG_W-1:0];
                CFG_BOX_LENGTH:  box_length_reg  <= cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dpea_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .image_count (image_count_reg),
        .stat        (stat),
        .cmd         (cmd)
    );

    dpea_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_distance  (s_tdata),
        .s_last      (s_tlast),
        .strength    (strength_reg),
        .box_length  (box_length_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_energy    (m_tdata),
        .m_saturated (saturated)
    );

    assign m_tuser = saturated;

endmodule
`default_nettype wire

FILE: rtl/dpea_checker.sv
// port-level checker for the dipolar pair energy accumulator and its bind
`default_nettype none
`include "assert_macros.svh"
module dpea_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_index,
    input wire logic [31:0] cfg_data
);
    // a stalled result holds
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `ASSERT_CLK(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    // an accepted transaction keeps the block busy for at least the next cycle
    `ASSERT_CLK(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input accepted again too early")
    // a total only appears at the end of an item's work
    `ASSERT_CLK(a_result_from_busy, $rose(m_tvalid) |-> $past(!s_tready), "result appeared while idle")
endmodule

bind dipolar_pair_energy_accumulator dpea_checker u_dpea_checker (.*);
`default_nettype wire

FILE: test/dipolar_pair_energy_accumulator_tb.sv
// self-checking testbench of the dipolar pair energy accumulator
`default_nettype none
module dipolar_pair_energy_accumulator_tb;
    import dpea_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [63:0] energy;
        logic        saturated;
    } energy_total_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow of the block state and registers
    logic [31:0] shadow_strength;
    logic [2:0]  shadow_images;
    logic [23:0] shadow_box;
    logic [63:0] shadow_sum;
    logic        shadow_flag;

    energy_total_t totals_pending[$];
    int unsigned   cycle_count;
    int unsigned   error_count;
    int unsigned   items_sent;
    int unsigned   totals_checked;
    int unsigned   cfg_writes;
    bit            no_idle;

    dipolar_pair_energy_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 24);
    endfunction

    // one signed reciprocal-cube term, D / d^3, with saturation
    function automatic logic [63:0] dipole_term(logic [26:0] mag, bit dist_neg);
        bit           s_neg;
        bit           neg;
        logic [32:0]  a;
        logic [127:0] num;
        logic [127:0] cube;
        logic [127:0] quot;
        logic [63:0]  limit;
        s_neg = shadow_strength[31];
        a = s_neg ? (33'h1_0000_0000 - {1'b0, shadow_strength}) : {1'b0, shadow_strength};
        neg = s_neg != dist_neg;
        if (mag == 0) begin
            shadow_flag = 1'b1;
            if (a == 0) return 64'd0;
            return s_neg ? SUM_MIN : SUM_MAX;
        end
        if (a == 0) return 64'd0;
        num = {31'd0, a, 64'd0};
        cube = 128'(mag) * 128'(mag) * 128'(mag);
        quot = num / cube;
        limit = neg ? SUM_MIN : SUM_MAX;
        if (quot > 128'(limit)) begin
            shadow_flag = 1'b1;
            quot = 128'(limit);
        end
        return neg ? (64'd0 - quot[63:0]) : quot[63:0];
    endfunction

    function automatic void add_to_sum(logic [63:0] t);
        logic [63:0] r;
        r = shadow_sum + t;
        if (shadow_sum[63] == t[63] && r[63] != shadow_sum[63]) begin
            shadow_sum = shadow_sum[63] ? SUM_MIN : SUM_MAX;
            shadow_flag = 1'b1;
        end else begin
            shadow_sum = r;
        end
    endfunction

    function automatic void predict_energy(logic [23:0] x, logic last);
        int unsigned   k;
        logic [26:0]   nl;
        energy_total_t tot;
        k = (shadow_images > MAX_IMG_CODE) ? MAX_IMAGES : shadow_images;
        add_to_sum(dipole_term(27'(x), 1'b0));
        for (int n = 1; n <= k; n++) begin
            nl = 27'(n) * 27'(shadow_box);
            add_to_sum(dipole_term(27'(x) + nl, 1'b0));
            if (nl >= 27'(x)) add_to_sum(dipole_term(nl - 27'(x), 1'b0));
            else add_to_sum(dipole_term(27'(x) - nl, 1'b1));
        end
        if (last) begin
            tot.energy = shadow_sum;
            tot.saturated = shadow_flag;
            totals_pending.push_back(tot);
            shadow_sum = 64'd0;
            shadow_flag = 1'b0;
        end
    endfunction

    task automatic send_distance(logic [23:0] x, logic last);
        bit taken;
        if (idle_now()) begin
            s_tvalid <= 1'b0;
            while (idle_now()) @(posedge aclk);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tlast <= last;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        predict_energy(x, last);
        items_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_STRENGTH:    shadow_strength = value;
            CFG_IMAGE_COUNT: shadow_images = value[2:0];
            CFG_BOX_LENGTH:  shadow_box = value[23:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (totals_pending.size() != 0) @(posedge aclk);
        // let the engine finish before touching the registers
        repeat (20) @(posedge aclk);
    endtask

    task automatic configure(logic [31:0] d, logic [2:0] k, logic [23:0] box);
        drain();
        write_reg(CFG_STRENGTH, d);
        write_reg(CFG_IMAGE_COUNT, {29'd0, k});
        write_reg(CFG_BOX_LENGTH, {8'd0, box});
    endtask

    // receiver: random stalls, check at negedge when the transaction is settled
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !idle_now();
    end

    always @(negedge aclk) begin
        energy_total_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (totals_pending.size() == 0) begin
                $display("%0t unexpected total: energy %h saturated %b",
                         $time, m_tdata, m_tuser[0]);
                error_count++;
            end else begin
                want = totals_pending.pop_front();
                totals_checked++;
                if (m_tdata !== want.energy) begin
                    $display("%0t energy mismatch: expected %h actual %h",
                             $time, want.energy, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== want.saturated) begin
                    $display("%0t saturated mismatch: expected %b actual %b",
                             $time, want.saturated, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_distance(24'h010000, 1'b0);
        send_distance(24'hFFFFFF, 1'b1);
        drain();
    endtask

    task automatic test_zero_and_saturation();
        send_distance(24'h000000, 1'b1);              // zero divisor
        send_distance(24'h000010, 1'b1);              // term too large
        configure(32'h7FFFFFFF, 3'd0, 24'h010000);
        send_distance(24'd1700, 1'b0);                // sum overflow upward
        send_distance(24'd1700, 1'b1);
        configure(32'h80000000, 3'd0, 24'h010000);
        send_distance(24'd1700, 1'b0);                // sum overflow downward
        send_distance(24'd1700, 1'b1);
        send_distance(24'h000000, 1'b1);
        configure(32'h00000000, 3'd0, 24'h010000);
        send_distance(24'h000000, 1'b1);              // zero strength, zero divisor
        drain();
    endtask

    task automatic test_image_shells();
        configure(32'h00010000, 3'd2, 24'h020000);
        send_distance(24'h018000, 1'b1);
        send_distance(24'h030000, 1'b1);              // nL - x negative for n = 1
        send_distance(24'h020000, 1'b1);              // nL - x zero
        configure(32'hFFFF0000, 3'd7, 24'h040000);    // count clamped
        send_distance(24'h050000, 1'b1);
        configure(32'h00020000, 3'd4, 24'h000000);    // zero box
        send_distance(24'h010000, 1'b1);
        configure(32'h00010000, 3'd5, 24'hFFFFFF);
        send_distance(24'hFFFFFF, 1'b1);
        drain();
        write_reg(2'd3, 32'hFFFFFFFF);                // unused index
        send_distance(24'h008000, 1'b1);
        drain();
    endtask

    task automatic test_random_runs(int unsigned phases, int unsigned per_phase);
        logic [31:0] d;
        logic [2:0]  k;
        logic [23:0] box;
        logic [23:0] x;
        int unsigned run_left;
        for (int p = 0; p < phases; p++) begin
            no_idle = (p >= 6 && p < 9);
            case ($urandom_range(0, 9))
                0: d = 32'h7FFFFFFF;
                1: d = 32'h80000000;
                2: d = $urandom();
                default: d = $urandom_range(0, 32'h3FFFF) ^ ($urandom_range(0, 1) ? '1 : '0);
            endcase
            k = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
            box = $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(1, 24'hFFFFF));
            configure(d, k, box);
            run_left = $urandom_range(1, 6);
            for (int i = 0; i < (k != 0 ? per_phase / 4 : per_phase); i++) begin
                case ($urandom_range(0, 15))
                    0: x = 24'($urandom());
                    1: x = ($urandom_range(0, 7) == 0) ? 24'd0 : 24'($urandom_range(1, 24'hFF));
                    default: x = 24'($urandom_range(24'h800, 24'h7FFFF));
                endcase
                run_left--;
                send_distance(x, run_left == 0 || i == (k != 0 ? per_phase / 4 : per_phase) - 1);
                if (run_left == 0) run_left = $urandom_range(1, 6);
            end
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        error_count = 0;
        items_sent = 0;
        totals_checked = 0;
        cfg_writes = 0;
        no_idle = 1'b0;
        shadow_strength = 32'h00010000;
        shadow_images = 3'd0;
        shadow_box = 24'hFFFFFF;
        shadow_sum = 64'd0;
        shadow_flag = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_zero_and_saturation();
        test_image_shells();
        test_random_runs(32, 68);

        drain();
        $display("sent %0d distances over %0d register writes, checked %0d totals",
                 items_sent, cfg_writes, totals_checked);
        $display("covered zero divisors, term and sum saturation, image shells and random runs");
        if (error_count == 0 && totals_pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors, %0d totals never arrived", error_count, totals_pending.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
